@@ sv/tnef_pkg.sv @@
// shared types and constants for the terminal name entry filter
package tnef_pkg;

    // name buffer geometry
    localparam int NAME_MAX = 16;
    localparam int LEN_W    = 5;
    localparam int IDX_W    = 4;
    localparam int CHAR_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;

    localparam logic [LEN_W-1:0] NAME_MAX_LEN = LEN_W'(NAME_MAX);
    localparam logic [LEN_W-1:0] MIN_LEN_RST  = LEN_W'(3);

    // special byte codes
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1b;
    localparam logic [BYTE_W-1:0] BYTE_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] BYTE_DEL   = 8'h7f;
    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] FINAL_LO   = 8'h40;
    localparam logic [BYTE_W-1:0] FINAL_HI   = 8'h7e;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NAME   = 2'd3;

    // byte filter mode
    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_ESC_FIRST = 2'd1,
        MODE_ESC_BODY  = 2'd2,
        MODE_UTF8      = 2'd3
    } skip_mode_t;

    // control sequencer
    typedef enum logic {
        ST_IDLE    = 1'b0,
        ST_READOUT = 1'b1
    } ctrl_state_t;

    // classification of one input byte
    typedef struct packed {
        logic       is_esc;
        logic       is_high;
        logic [1:0] utf8_n;
        logic       is_name;
        logic       is_erase;
        logic       is_enter;
        logic       is_final;
    } byte_class_t;

endpackage

@@ sv/tnef_byte_class.sv @@
// classifies one terminal byte for the name entry filter
module tnef_byte_class (
    input  logic [tnef_pkg::BYTE_W-1:0] byte_in,
    output tnef_pkg::byte_class_t       cls
);
    import tnef_pkg::*;

    // character classes and utf-8 lead decoding
    always_comb begin
        cls = '0;
        cls.is_esc   = (byte_in == BYTE_ESC);
        cls.is_high  = byte_in[7];
        if (byte_in[7:5] == 3'b110) begin
            cls.utf8_n = 2'd1;
        end else if (byte_in[7:4] == 4'b1110) begin
            cls.utf8_n = 2'd2;
        end else if (byte_in[7:3] == 5'b11110) begin
            cls.utf8_n = 2'd3;
        end else begin
            cls.utf8_n = 2'd0;
        end
        cls.is_name  = ((byte_in >= 8'h61) && (byte_in <= 8'h7a)) ||
                       ((byte_in >= 8'h41) && (byte_in <= 8'h5a)) ||
                       ((byte_in >= 8'h30) && (byte_in <= 8'h39)) ||
                       (byte_in == 8'h5f);
        cls.is_erase = (byte_in == BYTE_BS) || (byte_in == BYTE_DEL);
        cls.is_enter = (byte_in == BYTE_LF) || (byte_in == BYTE_CR);
        cls.is_final = (byte_in >= FINAL_LO) && (byte_in <= FINAL_HI);
    end

endmodule

@@ sv/tnef_name_ram.sv @@
// name character store, one write and one registered read port
module tnef_name_ram (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [tnef_pkg::IDX_W-1:0]  wr_addr,
    input  logic [tnef_pkg::CHAR_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [tnef_pkg::IDX_W-1:0]  rd_addr,
    output logic [tnef_pkg::CHAR_W-1:0] rd_data
);
    import tnef_pkg::*;

    logic [CHAR_W-1:0] mem [NAME_MAX];
    logic [CHAR_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/terminal_name_entry_filter.sv @@
// top level of the terminal name entry filter
//
// Input channel s_*: one raw terminal byte per word (s_byte_in), valid/ready.
// Result channel m_*: kind, char_out, position, name_length and last per word.
// Config: cfg_wr_en writes cfg_wr_data into min_length at once, no handshake.
// Every byte gives one result word with last set, except a CR/LF taken at a
// length from min_length (0 as 1) to 16, giving one kind 3 word per stored
// name character, last on the final. A result is registered, shown in the
// cycle after the byte is taken. One byte is taken per cycle while results
// are taken; an accepted name is read out one character per cycle while
// results are taken, set by the single registered read port of the store.
// No byte is taken during readout.
// Reset (aresetn low at a clock edge) empties the buffer, returns to normal
// character mode, sets min_length to 3 and drops any pending result.
// The name store itself is not cleared; only written entries are read.
// When m_ready is low the result word holds; the next byte is still taken
// if the result register frees in the same cycle.
module terminal_name_entry_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [tnef_pkg::LEN_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tnef_pkg::BYTE_W-1:0] s_byte_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tnef_pkg::KIND_W-1:0] m_kind,
    output logic [tnef_pkg::CHAR_W-1:0] m_char_out,
    output logic [tnef_pkg::IDX_W-1:0]  m_position,
    output logic [tnef_pkg::LEN_W-1:0]  m_name_length,
    output logic                        m_last
);
    import tnef_pkg::*;

    byte_class_t       cls;
    ctrl_state_t       state_reg, state_next;
    skip_mode_t        mode_reg, mode_next;
    logic [1:0]        skip_rem_reg, skip_rem_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  min_len_reg;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  nlen_reg, nlen_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              in_acc;
    logic              emit;
    logic              start_read;
    logic              rd_last;
    logic [LEN_W-1:0]  min_eff;
    logic              can_append;
    logic              can_erase;
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [CHAR_W-1:0] rd_data;

    tnef_byte_class u_class (
        .byte_in (s_byte_in),
        .cls     (cls)
    );

    tnef_name_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (len_reg[IDX_W-1:0]),
        .wr_data (s_byte_in[CHAR_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // decision terms for a byte in normal mode
    assign out_free   = !m_valid_reg || m_ready;
    assign in_acc     = s_valid && s_ready;
    assign min_eff    = (min_len_reg == '0) ? LEN_W'(1) : min_len_reg;
    assign can_append = cls.is_name && (len_reg < NAME_MAX_LEN);
    assign can_erase  = cls.is_erase && (len_reg != '0);
    assign start_read = in_acc && (mode_reg == MODE_NORMAL) && cls.is_enter &&
                        (len_reg >= min_eff) && (len_reg <= NAME_MAX_LEN);
    assign wr_en      = in_acc && (mode_reg == MODE_NORMAL) && can_append;
    assign rd_last    = (LEN_W'(rd_idx_reg) + LEN_W'(1)) == len_reg;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_read) begin
                    state_next = ST_READOUT;
                end
            end
            ST_READOUT: begin
                if (emit && rd_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_ready = out_free;
            ST_READOUT: emit    = out_free;
            default: begin
                s_ready = 1'b0;
                emit    = 1'b0;
            end
        endcase
    end

    // store read address: first entry on accept, next entry on each emit
    always_comb begin
        rd_en       = start_read || (emit && !rd_last);
        rd_addr     = start_read ? '0 : rd_idx_reg + IDX_W'(1);
        rd_idx_next = rd_idx_reg;
        if (start_read) begin
            rd_idx_next = '0;
        end else if (emit) begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end
    end

    // filter state, buffer length and result word
    always_comb begin
        mode_next     = mode_reg;
        skip_rem_next = skip_rem_reg;
        len_next      = len_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        char_next     = char_reg;
        pos_next      = pos_reg;
        nlen_next     = nlen_reg;
        last_next     = last_reg;
        if (in_acc && !start_read) begin
            kind_next = KIND_DROP;
            char_next = '0;
            case (mode_reg)
                MODE_ESC_FIRST: mode_next = MODE_ESC_BODY;
                MODE_ESC_BODY: begin
                    if (cls.is_final) begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_UTF8: begin
                    if (skip_rem_reg <= 2'd1) begin
                        skip_rem_next = '0;
                        mode_next     = MODE_NORMAL;
                    end else begin
                        skip_rem_next = skip_rem_reg - 2'd1;
                    end
                end
                default: begin
                    if (cls.is_esc) begin
                        mode_next = MODE_ESC_FIRST;
                    end else if (cls.is_high) begin
                        if (cls.utf8_n != 2'd0) begin
                            mode_next     = MODE_UTF8;
                            skip_rem_next = cls.utf8_n;
                        end
                    end else if (can_append) begin
                        len_next  = len_reg + LEN_W'(1);
                        kind_next = KIND_APPEND;
                        char_next = s_byte_in[CHAR_W-1:0];
                    end else if (can_erase) begin
                        len_next  = len_reg - LEN_W'(1);
                        kind_next = KIND_ERASE;
                    end
                end
            endcase
            m_valid_next = 1'b1;
            pos_next     = '0;
            nlen_next    = len_next;
            last_next    = 1'b1;
        end else if (emit) begin
            m_valid_next = 1'b1;
            kind_next    = KIND_NAME;
            char_next    = rd_data;
            pos_next     = rd_idx_reg;
            nlen_next    = len_reg;
            last_next    = rd_last;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_NORMAL;
            skip_rem_reg <= '0;
            len_reg      <= '0;
            min_len_reg  <= MIN_LEN_RST;
            rd_idx_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            skip_rem_reg <= skip_rem_next;
            len_reg      <= len_next;
            rd_idx_reg   <= rd_idx_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                min_len_reg <= cfg_wr_data;
            end
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        char_reg <= char_next;
        pos_reg  <= pos_next;
        nlen_reg <= nlen_next;
        last_reg <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_char_out    = char_reg;
    assign m_position    = pos_reg;
    assign m_name_length = nlen_reg;
    assign m_last        = last_reg;

endmodule
